// ===== hw/rtl/utf8_bom_stream_decoder_assert.svh =====
// Assertion macros, clocked on clk and disabled during rst.
`ifndef UTF8_BOM_STREAM_DECODER_ASSERT_SVH
`define UTF8_BOM_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication.
`define UBSD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ubsd assertion failed");

// Next-cycle implication.
`define UBSD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ubsd assertion failed");

`endif

// ===== hw/rtl/ubsd_pkg.sv =====
`timescale 1ns / 1ps
package ubsd_pkg;

  localparam int CP_W    = 21;
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  localparam logic [7:0] MARK_B0 = 8'hEF;
  localparam logic [7:0] MARK_B1 = 8'hBB;
  localparam logic [7:0] MARK_B2 = 8'hBF;

  localparam logic [1:0] MARK_P0 = 2'd0;
  localparam logic [1:0] MARK_P1 = 2'd1;
  localparam logic [1:0] MARK_P2 = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_MARK = 2'd1;
  localparam logic [1:0] ST_BAD_DATA = 2'd2;

  typedef enum logic [2:0] {
    CLS_EOS,
    CLS_ASCII,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_CONT,
    CLS_BAD
  } byte_class_t;

  typedef struct packed {
    byte_class_t cls;
    logic [7:0]  data;
  } cmd_t;

endpackage

// ===== hw/rtl/ubsd_front.sv =====
`timescale 1ns / 1ps
module ubsd_front
  import ubsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_opcode,
  input  logic [7:0] in_byte,
  output logic       cmd_valid,
  input  logic       cmd_ready,
  output cmd_t       cmd
);

  byte_class_t cls_next;
  logic        take;

  always_comb begin
    if (in_opcode) begin
      cls_next = CLS_EOS;
    end else if (!in_byte[7]) begin
      cls_next = CLS_ASCII;
    end else if (!in_byte[6]) begin
      cls_next = CLS_CONT;
    end else if (!in_byte[5]) begin
      cls_next = CLS_LEAD2;
    end else if (!in_byte[4]) begin
      cls_next = CLS_LEAD3;
    end else if (!in_byte[3]) begin
      cls_next = CLS_LEAD4;
    end else begin
      cls_next = CLS_BAD;
    end
  end

  assign in_ready = !cmd_valid || cmd_ready;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (in_ready) begin
      cmd_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd.cls  <= cls_next;
      cmd.data <= in_byte;
    end
  end

endmodule

// ===== hw/rtl/ubsd_fifo.sv =====
`timescale 1ns / 1ps
module ubsd_fifo
  import ubsd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic empty
);

  cmd_t            slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   count;
  logic            do_push;
  logic            do_pop;

  assign full     = (count == (Q_AW+1)'(Q_DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== hw/rtl/ubsd_back.sv =====
`timescale 1ns / 1ps
`include "utf8_bom_stream_decoder_assert.svh"
module ubsd_back
  import ubsd_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_pop,
  input  cmd_t            cmd,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [CP_W-1:0] out_code_point,
  output logic [1:0]      out_status
);

  logic            mark_seen;
  logic            mark_seen_next;
  logic [1:0]      mark_progress;
  logic [1:0]      mark_progress_next;
  logic [1:0]      bytes_remaining;
  logic [1:0]      bytes_remaining_next;
  logic [CP_W-1:0] partial_char;
  logic [CP_W-1:0] partial_char_next;
  logic [CP_W-1:0] shifted;
  logic            emit;
  logic [CP_W-1:0] emit_cp;
  logic [1:0]      emit_st;
  logic            mark_ok;

  assign cmd_pop = cmd_valid && (!out_valid || out_ready);
  assign shifted = {partial_char[CP_W-7:0], cmd.data[5:0]};

  always_comb begin
    case (mark_progress)
      MARK_P0: mark_ok = (cmd.data == MARK_B0);
      MARK_P1: mark_ok = (cmd.data == MARK_B1);
      MARK_P2: mark_ok = (cmd.data == MARK_B2);
      default: mark_ok = 1'b0;
    endcase
  end

  always_comb begin
    mark_seen_next       = mark_seen;
    mark_progress_next   = mark_progress;
    bytes_remaining_next = bytes_remaining;
    partial_char_next    = partial_char;
    emit                 = 1'b0;
    emit_cp              = '0;
    emit_st              = ST_OK;
    if (cmd.cls == CLS_EOS) begin
      mark_progress_next   = '0;
      bytes_remaining_next = '0;
      partial_char_next    = '0;
    end else if (!mark_seen) begin
      if (!mark_ok) begin
        mark_progress_next = '0;
        emit               = 1'b1;
        emit_st            = ST_BAD_MARK;
      end else if (mark_progress == MARK_P2) begin
        mark_seen_next     = 1'b1;
        mark_progress_next = '0;
      end else begin
        mark_progress_next = mark_progress + 1'b1;
      end
    end else if (bytes_remaining != '0) begin
      bytes_remaining_next = bytes_remaining - 1'b1;
      if (bytes_remaining == 2'd1) begin
        partial_char_next = '0;
        emit              = 1'b1;
        emit_cp           = shifted;
      end else begin
        partial_char_next = shifted;
      end
    end else begin
      case (cmd.cls)
        CLS_ASCII: begin
          emit    = 1'b1;
          emit_cp = {{(CP_W-7){1'b0}}, cmd.data[6:0]};
        end
        CLS_LEAD2: begin
          partial_char_next    = {{(CP_W-5){1'b0}}, cmd.data[4:0]};
          bytes_remaining_next = 2'd1;
        end
        CLS_LEAD3: begin
          partial_char_next    = {{(CP_W-4){1'b0}}, cmd.data[3:0]};
          bytes_remaining_next = 2'd2;
        end
        CLS_LEAD4: begin
          partial_char_next    = {{(CP_W-3){1'b0}}, cmd.data[2:0]};
          bytes_remaining_next = 2'd3;
        end
        default: begin
          partial_char_next = '0;
          emit              = 1'b1;
          emit_st           = ST_BAD_DATA;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mark_seen       <= 1'b0;
      mark_progress   <= '0;
      bytes_remaining <= '0;
      partial_char    <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cmd_pop) begin
        mark_seen       <= mark_seen_next;
        mark_progress   <= mark_progress_next;
        bytes_remaining <= bytes_remaining_next;
        partial_char    <= partial_char_next;
      end
      if (cmd_pop && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && emit) begin
      out_code_point <= emit_cp;
      out_status     <= emit_st;
    end
  end

  `UBSD_ASSERT_IMP(a_progress_range, 1'b1, mark_progress != 2'd3)
  `UBSD_ASSERT_NXT(a_mark_sticky, mark_seen, mark_seen)
  `UBSD_ASSERT_IMP(a_decode_after_mark, bytes_remaining != 2'd0, mark_seen && mark_progress == 2'd0)
  `UBSD_ASSERT_IMP(a_error_zero_cp, out_valid && out_status != ST_OK, out_code_point == '0)

endmodule

// ===== hw/rtl/utf8_bom_stream_decoder.sv =====
`timescale 1ns / 1ps
// UTF-8 decoder for a byte stream that must open with the mark EF BB BF.
// Input words on s_axis: tdata carries the byte, tuser the opcode
// (0 = data byte, 1 = end of source). Output words on m_axis: tdata
// carries the 21-bit code point, tuser the status (0 ok, 1 bad mark,
// 2 bad data). Mark bytes, lead bytes and inner continuation bytes of
// multi-byte characters and end of source produce no output word; every
// other byte produces exactly one.
// Throughput: one input word per cycle, sustained while m_axis_tready is
// high. A front stage classifies each byte into a register, a four-entry
// queue decouples it from the decoder, and the decoder retires one queued
// word per cycle into the output register unless a held word stalls it.
// A byte passes the front register and a queue slot before the output.
// Reset (rst, synchronous) clears the mark detector, the partial character
// and all queued words; the mark must then be seen again.
// When m_axis_tready is low a pending output word holds, the decoder stops,
// the queue and front stage fill, and s_axis_tready drops once both are full.
module utf8_bom_stream_decoder
  import ubsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] byte_value
  input  logic        s_axis_tuser,  // [0] opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [20:0] code_point, [23:21] zero
  output logic [1:0]  m_axis_tuser   // [1:0] status
);

  logic            f_valid;
  logic            f_ready;
  cmd_t            f_cmd;
  logic            q_full;
  logic            q_empty;
  logic            q_pop;
  cmd_t            q_cmd;
  logic [CP_W-1:0] code_point;

  ubsd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_opcode (s_axis_tuser),
    .in_byte   (s_axis_tdata),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  assign f_ready = !q_full;

  ubsd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (f_valid),
    .push_data (f_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_cmd),
    .empty     (q_empty)
  );

  ubsd_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (!q_empty),
    .cmd_pop        (q_pop),
    .cmd            (q_cmd),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_code_point (code_point),
    .out_status     (m_axis_tuser)
  );

  assign m_axis_tdata = {{(24-CP_W){1'b0}}, code_point};

endmodule

// ===== tb/sv/utf8_bom_stream_decoder_tb.sv =====
`timescale 1ns / 1ps
module utf8_bom_stream_decoder_tb;
  import ubsd_pkg::*;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_EOS  = 1'b1;

  localparam int RX_HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int PHASE_WORDS    = 400;
  localparam int SETTLE_CYCLES  = 10;

  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic [1:0]      st;
  } char_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tuser = OP_BYTE;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  utf8_bom_stream_decoder i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // decoder state as predicted
  logic            dec_mark_seen = 1'b0;
  logic [1:0]      dec_mark_pos  = MARK_P0;
  logic [1:0]      dec_cont_left = 2'd0;
  logic [CP_W-1:0] dec_partial   = '0;

  char_result_t expected_chars[$];
  char_result_t got_char;
  int           mismatches = 0;
  int           sent_words = 0;
  int           cycle_cnt  = 0;
  bit           tx_idle_en = 1'b1;
  bit           rx_idle_en = 1'b1;
  int           hold_req   = 0;
  int           hold_taken = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d words still awaited", $time, expected_chars.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic void note_char(logic [CP_W-1:0] cp, logic [1:0] st);
    char_result_t r;
    r.cp = cp;
    r.st = st;
    expected_chars.push_back(r);
  endfunction

  function automatic void predict_char(logic op, logic [7:0] oct);
    if (op == OP_EOS) begin
      dec_mark_pos  = MARK_P0;
      dec_cont_left = 2'd0;
      dec_partial   = '0;
    end else if (!dec_mark_seen) begin
      if ((dec_mark_pos == MARK_P0 && oct == MARK_B0) ||
          (dec_mark_pos == MARK_P1 && oct == MARK_B1) ||
          (dec_mark_pos == MARK_P2 && oct == MARK_B2)) begin
        if (dec_mark_pos == MARK_P2) begin
          dec_mark_seen = 1'b1;
          dec_mark_pos  = MARK_P0;
        end else begin
          dec_mark_pos = dec_mark_pos + 2'd1;
        end
      end else begin
        dec_mark_pos = MARK_P0;
        note_char('0, ST_BAD_MARK);
      end
    end else if (dec_cont_left != 2'd0) begin
      // top bits of a continuation byte are not checked
      dec_partial   = {dec_partial[CP_W-7:0], oct[5:0]};
      dec_cont_left = dec_cont_left - 2'd1;
      if (dec_cont_left == 2'd0) begin
        note_char(dec_partial, ST_OK);
        dec_partial = '0;
      end
    end else if (!oct[7]) begin
      note_char(CP_W'(oct[6:0]), ST_OK);
    end else if (oct[7:5] == 3'b110) begin
      dec_partial   = CP_W'(oct[4:0]);
      dec_cont_left = 2'd1;
    end else if (oct[7:4] == 4'b1110) begin
      dec_partial   = CP_W'(oct[3:0]);
      dec_cont_left = 2'd2;
    end else if (oct[7:3] == 5'b11110) begin
      dec_partial   = CP_W'(oct[2:0]);
      dec_cont_left = 2'd3;
    end else begin
      dec_partial = '0;
      note_char('0, ST_BAD_DATA);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual cp %06h status %0d",
                 $time, m_axis_tdata, m_axis_tuser);
        mismatches++;
      end else begin
        got_char = expected_chars.pop_front();
        if (m_axis_tdata != {3'b000, got_char.cp}) begin
          $display("%0t: code point expected %06h actual %06h",
                   $time, got_char.cp, m_axis_tdata);
          mismatches++;
        end
        if (m_axis_tuser != got_char.st) begin
          $display("%0t: status expected %0d actual %0d", $time, got_char.st, m_axis_tuser);
          mismatches++;
        end
      end
    end
  end

  // sink side: random stalls, plus a long hold-off on request
  initial begin : sink_side
    int w;
    while (rst) @(posedge clk);
    forever begin
      if (hold_req != hold_taken) begin
        hold_taken++;
        m_axis_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end
      w = rx_idle_en ? $urandom_range(0, 5) : 0;
      if (w > 0) begin
        m_axis_tready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk);
      while (!(m_axis_tvalid && m_axis_tready) && hold_req == hold_taken);
    end
  end

  task automatic send_word(input logic op, input logic [7:0] oct);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= oct;
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    predict_char(op, oct);
    sent_words++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (expected_chars.size() != 0);
  endtask

  // len-byte character, now and then malformed or cut short by end of source
  task automatic send_char(input int len);
    logic [7:0] lead;
    logic [7:0] cont;
    case (len)
      1:       lead = {1'b0, 7'($urandom)};
      2:       lead = {3'b110, 5'($urandom)};
      3:       lead = {4'b1110, 4'($urandom)};
      default: lead = {5'b11110, 3'($urandom)};
    endcase
    send_word(OP_BYTE, lead);
    for (int i = 1; i < len; i++) begin
      if ($urandom_range(0, 39) == 0) begin
        send_word(OP_EOS, 8'($urandom));
        return;
      end
      cont = ($urandom_range(0, 9) == 0) ? 8'($urandom) : {2'b10, 6'($urandom)};
      send_word(OP_BYTE, cont);
    end
  endtask

  task automatic send_unit();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30)
      send_char(1);
    else if (r < 50)
      send_char(2);
    else if (r < 65)
      send_char(3);
    else if (r < 80)
      send_char(4);
    else if (r < 88)
      send_word(OP_BYTE, $urandom_range(0, 1) ? {2'b10, 6'($urandom)}
                                              : {5'b11111, 3'($urandom)});
    else if (r < 95)
      send_word(OP_BYTE, 8'($urandom));
    else
      send_word(OP_EOS, 8'($urandom));
  endtask

  task automatic test_mark_errors();
    send_word(OP_BYTE, 8'h00);
    send_word(OP_BYTE, MARK_B0);
    send_word(OP_BYTE, 8'h41);
    send_word(OP_BYTE, MARK_B0);
    send_word(OP_BYTE, MARK_B1);
    send_word(OP_BYTE, 8'hFF);
    // partial mark dropped at end of source
    send_word(OP_BYTE, MARK_B0);
    send_word(OP_BYTE, MARK_B1);
    send_word(OP_EOS, MARK_B2);
    wait_drained();
  endtask

  // random bytes around the mark until it is complete
  task automatic test_mark_hunt();
    int         n;
    int         odds;
    logic [7:0] good;
    n = 0;
    while (!dec_mark_seen) begin
      case (dec_mark_pos)
        MARK_P0: good = MARK_B0;
        MARK_P1: good = MARK_B1;
        default: good = MARK_B2;
      endcase
      odds = (n >= 60) ? 100 : (dec_mark_pos == MARK_P2) ? 15 : 70;
      if (n < 60 && $urandom_range(0, 9) == 0)
        send_word(OP_EOS, 8'($urandom));
      else if ($urandom_range(1, 100) <= odds)
        send_word(OP_BYTE, good);
      else
        send_word(OP_BYTE, 8'($urandom));
      n++;
    end
    wait_drained();
  endtask

  task automatic test_lead_bytes();
    send_word(OP_BYTE, 8'h00);
    send_word(OP_BYTE, 8'h7F);
    send_word(OP_BYTE, 8'hC2);
    send_word(OP_BYTE, 8'h3F);
    send_word(OP_BYTE, 8'hE2);
    send_word(OP_BYTE, 8'h82);
    send_word(OP_BYTE, 8'hAC);
    // largest value a four-byte sequence can carry
    send_word(OP_BYTE, 8'hF7);
    send_word(OP_BYTE, 8'hBF);
    send_word(OP_BYTE, 8'hFF);
    send_word(OP_BYTE, 8'hFF);
    send_word(OP_BYTE, 8'h80);
    send_word(OP_BYTE, 8'hF8);
    send_word(OP_BYTE, 8'hE1);
    send_word(OP_EOS, 8'h00);
    wait_drained();
  endtask

  task automatic test_random_stream();
    int stop_at;
    for (int phase = 0; phase < 4; phase++) begin
      tx_idle_en = (phase == 0 || phase == 2);
      rx_idle_en = (phase == 0 || phase == 3);
      stop_at = sent_words + PHASE_WORDS;
      while (sent_words < stop_at) send_unit();
      wait_drained();
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  task automatic test_backpressure();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    hold_req++;
    repeat (40) send_word(OP_BYTE, {1'b0, 7'($urandom)});
    wait_drained();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  task automatic test_drain_pause();
    repeat (6) begin
      repeat (10) send_unit();
      wait_drained();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_mark_errors();
    test_mark_hunt();
    test_lead_bytes();
    test_random_stream();
    test_backpressure();
    test_drain_pause();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
